### hdl/savitzky_golay_smoother_assert.svh
// assertion macros used by the smoother controller (sgs_ctrl)
`ifndef SAVITZKY_GOLAY_SMOOTHER_ASSERT_SVH
`define SAVITZKY_GOLAY_SMOOTHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SGS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgs: implication check failed");

// next-cycle implication
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgs: next-cycle check failed");

`else

`define SGS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/sgs_pkg.sv
`default_nettype none

package sgs_pkg;

   // field widths
   localparam int SAMPLE_IN_W  = 16;
   localparam int OUT_W        = 22;
   localparam int FRAC_BITS    = 4;
   localparam int WL_W         = 5;
   localparam int PO_W         = 3;
   localparam int SEEN_W       = 6;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // half window and tap age
   localparam int M_W          = 4;
   localparam int AGE_W        = 5;

   // filter arithmetic
   localparam int BASE_W       = 11;
   localparam int DEN_W        = 14;
   localparam int DIV_W        = DEN_W + 1;
   localparam int WGT_W        = 13;
   localparam int TAP_GROWTH_W = 5;
   localparam int NUM_SHIFT    = FRAC_BITS + 1;

   // register reset values and valid settings
   localparam logic [WL_W-1:0]   WL_RESET  = 5'd5;
   localparam logic [WL_W-1:0]   WL_MIN    = 5'd5;
   localparam logic [PO_W-1:0]   PO_RESET  = 3'd2;
   localparam logic [PO_W-1:0]   PO_QUAD   = 3'd2;
   localparam logic [PO_W-1:0]   PO_CUBIC  = 3'd3;
   localparam logic [SEEN_W-1:0] SEEN_MAX  = 6'd63;

   // register indexes
   localparam logic CSR_IDX_WINDOW = 1'b0;
   localparam logic CSR_IDX_ORDER  = 1'b1;

   // output saturation limits
   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW_READ,
      ST_RAW_OUT,
      ST_MAC,
      ST_MAC_DRAIN,
      ST_DIV,
      ST_SMOOTH_OUT
   } sgs_state_type;

   // controller to datapath
   typedef struct packed {
      logic             accept;
      logic             rd_en;
      logic [AGE_W-1:0] rd_age;
      logic             mac;
      logic             acc_clear;
      logic             div_start;
      logic             load_raw;
      logic             load_smooth;
      logic             eor;
   } sgs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic              cfg_valid;
      logic [M_W-1:0]    m;
      logic [SEEN_W-1:0] seen;
      logic              mac_busy;
      logic              div_busy;
      logic              out_free;
   } sgs_sts_type;

   // centre weight 3(3m^2+3m-1)
   function automatic logic [BASE_W-1:0] sgs_base(input logic [M_W-1:0] m);
      logic [BASE_W-1:0] val;
      case (m)
         4'd2:    val = 11'd51;
         4'd3:    val = 11'd105;
         4'd4:    val = 11'd177;
         4'd5:    val = 11'd267;
         4'd6:    val = 11'd375;
         4'd7:    val = 11'd501;
         4'd8:    val = 11'd645;
         4'd9:    val = 11'd807;
         4'd10:   val = 11'd987;
         4'd11:   val = 11'd1185;
         4'd12:   val = 11'd1401;
         default: val = '0;
      endcase
      return val;
   endfunction

   // normaliser (2m-1)(2m+1)(2m+3)
   function automatic logic [DEN_W-1:0] sgs_den(input logic [M_W-1:0] m);
      logic [DEN_W-1:0] val;
      case (m)
         4'd2:    val = 14'd105;
         4'd3:    val = 14'd315;
         4'd4:    val = 14'd693;
         4'd5:    val = 14'd1287;
         4'd6:    val = 14'd2145;
         4'd7:    val = 14'd3315;
         4'd8:    val = 14'd4845;
         4'd9:    val = 14'd6783;
         4'd10:   val = 14'd9177;
         4'd11:   val = 14'd12075;
         4'd12:   val = 14'd15525;
         default: val = 14'd1;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### hdl/sgs_div.sv
`default_nettype none

module sgs_div
   import sgs_pkg::*;
#(
   parameter int NUM_W = 41,
   parameter int DEN_BITS = 15
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_W-1:0]    num,
   input  wire logic [DEN_BITS-1:0] divisor,
   output logic                     busy,
   output logic [NUM_W-1:0]         quot_mag,
   output logic                     rem_nz,
   output logic                     neg
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0]    dvd_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS-1:0] div_ff;
   logic                neg_ff;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                qbit;

   // one restoring step per cycle on the magnitude
   assign trial = {rem_ff, dvd_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign qbit  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand load and shift
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[NUM_W-1];
         dvd_ff <= num[NUM_W-1] ? (~num + 1'b1) : num;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[NUM_W-2:0], qbit};
         rem_ff <= qbit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      end
   end

   assign busy     = busy_ff;
   assign quot_mag = dvd_ff;
   assign rem_nz   = |rem_ff;
   assign neg      = neg_ff;

endmodule

`default_nettype wire

### hdl/sgs_datapath.sv
`default_nettype none

module sgs_datapath
   import sgs_pkg::*;
#(
   parameter int MAX_WINDOW  = 25,
   parameter int RING_DEPTH  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [SAMPLE_IN_W-1:0]  req_sample,
   input  wire logic                    req_is_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_smoothed,
   output logic                         rsp_end_of_run,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready,
   input  wire sgs_cmd_type             cmd,
   output sgs_sts_type                  sts
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int PROD_W = SAMPLE_BITS + 1 + WGT_W;
   localparam int ACC_W  = PROD_W + TAP_GROWTH_W;
   localparam int NUM_W  = ACC_W + NUM_SHIFT + 1;
   localparam int RAW_W  = SAMPLE_BITS + FRAC_BITS;
   localparam logic [PTR_W-1:0] PTR_LAST       = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W:0]   RING_SIZE      = (PTR_W + 1)'(RING_DEPTH);
   localparam logic [PTR_W:0]   RING_LAST_EXT  = (PTR_W + 1)'(RING_DEPTH - 1);
   localparam logic [WL_W-1:0]  WL_MAX         = WL_W'(MAX_WINDOW);

   // configuration registers
   logic [WL_W-1:0]   window_length_ff;
   logic [PO_W-1:0]   poly_order_ff;
   logic              csr_write;
   logic              csr_idx;
   logic              cfg_valid;
   logic [M_W-1:0]    m;

   // sample store
   logic [SAMPLE_BITS-1:0] sample_ring [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] sample_ext;
   logic [PTR_W-1:0]       wp_ff;
   logic [SEEN_W-1:0]      seen_ff;
   logic [PTR_W:0]         idx_sum;
   logic [PTR_W:0]         idx_wrap;
   logic [PTR_W-1:0]       rd_idx;
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   // tap weights and accumulation
   logic [BASE_W-1:0]          base;
   logic [DEN_W-1:0]           den;
   logic [AGE_W-1:0]           m_ext;
   logic [AGE_W-1:0]           tap_gap;
   logic [M_W-1:0]             dist_n;
   logic [2*M_W-1:0]           sq;
   logic [WGT_W-2:0]           sq15;
   logic signed [WGT_W-1:0]    weight;
   logic signed [WGT_W-1:0]    weight_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [NUM_W-1:0]           num_ff;
   logic                       mac_v1_ff;
   logic                       mac_v2_ff;
   logic                       mac_v3_ff;

   // divider and result forming
   logic                       div_busy;
   logic [NUM_W-1:0]           div_quot;
   logic                       div_rem_nz;
   logic                       div_neg;
   logic [NUM_W:0]             mag_ext;
   logic signed [NUM_W:0]      q_s;
   logic [NUM_W-OUT_W+1:0]     q_top;
   logic                       q_ovf;
   logic [OUT_W-1:0]           smooth_val;
   logic [RAW_W-1:0]           raw_ext;
   logic [OUT_W-1:0]           raw_val;

   // output register
   logic                       rsp_valid_ff;
   logic [OUT_W-1:0]           smoothed_ff;
   logic                       eor_ff;

   // register port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WL_RESET;
         poly_order_ff    <= PO_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_IDX_WINDOW: window_length_ff <= csr_pwdata[WL_W-1:0];
            CSR_IDX_ORDER:  poly_order_ff    <= csr_pwdata[PO_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_WINDOW: csr_prdata = {{(CSR_DATA_W-WL_W){1'b0}}, window_length_ff};
         CSR_IDX_ORDER:  csr_prdata = {{(CSR_DATA_W-PO_W){1'b0}}, poly_order_ff};
      endcase
   end

   // setting check and half window
   assign cfg_valid = (window_length_ff >= WL_MIN) && (window_length_ff <= WL_MAX) &&
                      window_length_ff[0] &&
                      ((poly_order_ff == PO_QUAD) || (poly_order_ff == PO_CUBIC));
   assign m         = window_length_ff[WL_W-1:1];

   // stored sample width
   generate
      if (SAMPLE_BITS <= SAMPLE_IN_W) begin : g_narrow
         assign sample_ext = req_sample[SAMPLE_BITS-1:0];
      end else begin : g_wide
         assign sample_ext = {{(SAMPLE_BITS-SAMPLE_IN_W){1'b0}}, req_sample};
      end
   endgenerate

   // ring write, pointer and sample count
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ring[wp_ff] <= sample_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         seen_ff <= '0;
      end else if (csr_write) begin
         seen_ff <= '0;
      end else if (cmd.accept) begin
         wp_ff <= (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
         if (req_is_last) begin
            seen_ff <= '0;
         end else if (seen_ff != SEEN_MAX) begin
            seen_ff <= seen_ff + 1'b1;
         end
      end
   end

   // slot of the sample at a given age
   assign idx_sum  = {1'b0, wp_ff} + RING_LAST_EXT -
                     {{(PTR_W+1-AGE_W){1'b0}}, cmd.rd_age};
   assign idx_wrap = idx_sum - RING_SIZE;
   assign rd_idx   = (idx_sum >= RING_SIZE) ? idx_wrap[PTR_W-1:0] : idx_sum[PTR_W-1:0];

   // tap weight base - 15 i^2
   assign base    = sgs_base(m);
   assign den     = sgs_den(m);
   assign m_ext   = {1'b0, m};
   assign tap_gap = (cmd.rd_age >= m_ext) ? (cmd.rd_age - m_ext) : (m_ext - cmd.rd_age);
   assign dist_n  = tap_gap[M_W-1:0];
   assign sq      = {{M_W{1'b0}}, dist_n} * {{M_W{1'b0}}, dist_n};
   assign sq15    = {sq, 4'b0000} - {4'b0000, sq};
   assign weight  = {2'b00, base} - {1'b0, sq15};

   // read stage
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= sample_ring[rd_idx];
         weight_ff  <= weight;
      end
   end

   // multiply, accumulate, numerator
   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, rd_data_ff}) * weight_ff;
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (mac_v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      num_ff <= {acc_ff[ACC_W-1], acc_ff, {NUM_SHIFT{1'b0}}} +
                {{(NUM_W-DEN_W){1'b0}}, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v1_ff <= 1'b0;
         mac_v2_ff <= 1'b0;
         mac_v3_ff <= 1'b0;
      end else begin
         mac_v1_ff <= cmd.mac;
         mac_v2_ff <= mac_v1_ff;
         mac_v3_ff <= mac_v2_ff;
      end
   end

   // floor division by 2D
   sgs_div #(
      .NUM_W    (NUM_W),
      .DEN_BITS (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num_ff),
      .divisor  ({den, 1'b0}),
      .busy     (div_busy),
      .quot_mag (div_quot),
      .rem_nz   (div_rem_nz),
      .neg      (div_neg)
   );

   // sign fix and saturation of the quotient
   assign mag_ext    = {1'b0, div_quot};
   assign q_s        = div_neg ? -(mag_ext + {{NUM_W{1'b0}}, div_rem_nz}) : mag_ext;
   assign q_top      = q_s[NUM_W:OUT_W-1];
   assign q_ovf      = !((&q_top) || !(|q_top));
   assign smooth_val = q_ovf ? (q_s[NUM_W] ? OUT_MIN : OUT_MAX) : q_s[OUT_W-1:0];

   // raw sample with fraction bits
   assign raw_ext = {rd_data_ff, {FRAC_BITS{1'b0}}};
   generate
      if (RAW_W < OUT_W) begin : g_raw_fit
         assign raw_val = {{(OUT_W-RAW_W){1'b0}}, raw_ext};
      end else begin : g_raw_sat
         assign raw_val = (|raw_ext[RAW_W-1:OUT_W-1]) ? OUT_MAX :
                          {1'b0, raw_ext[OUT_W-2:0]};
      end
   endgenerate

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_raw || cmd.load_smooth) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_raw) begin
         smoothed_ff <= raw_val;
         eor_ff      <= cmd.eor;
      end else if (cmd.load_smooth) begin
         smoothed_ff <= smooth_val;
         eor_ff      <= cmd.eor;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_smoothed   = smoothed_ff;
   assign rsp_end_of_run = eor_ff;

   // status to the controller
   assign sts.cfg_valid = cfg_valid;
   assign sts.m         = m;
   assign sts.seen      = seen_ff;
   assign sts.mac_busy  = mac_v1_ff || mac_v2_ff || mac_v3_ff;
   assign sts.div_busy  = div_busy;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

### hdl/sgs_ctrl.sv
`default_nettype none

`include "savitzky_golay_smoother_assert.svh"

module sgs_ctrl
   import sgs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_is_last,
   input  wire sgs_sts_type sts,
   output sgs_cmd_type      cmd
);

   sgs_state_type    state_ff, state_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             main_ff, main_in;
   logic             last_ff, last_in;

   logic             accept;
   logic [AGE_W-1:0] m_ext;
   logic [AGE_W-1:0] two_m;
   logic             seen_ge_m;
   logic             seen_ge_2m;
   logic             mac_last;
   logic             flush_start;
   logic             flush_more;

   assign req_ready   = state_ff == ST_IDLE;
   assign accept      = req_valid && req_ready;
   assign m_ext       = {1'b0, sts.m};
   assign two_m       = {sts.m, 1'b0};
   assign seen_ge_m   = sts.seen >= {{(SEEN_W-AGE_W){1'b0}}, m_ext};
   assign seen_ge_2m  = sts.seen >= {{(SEEN_W-AGE_W){1'b0}}, two_m};
   assign mac_last    = age_ff == two_m;
   assign flush_start = main_ff && last_ff;
   assign flush_more  = !main_ff && (age_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (!sts.cfg_valid) begin
                  state_in = ST_RAW_READ;
               end else if (seen_ge_2m) begin
                  state_in = ST_MAC;
               end else if (seen_ge_m || req_is_last) begin
                  state_in = ST_RAW_READ;
               end
            end
         end
         ST_RAW_READ: begin
            state_in = ST_RAW_OUT;
         end
         ST_RAW_OUT, ST_SMOOTH_OUT: begin
            if (sts.out_free) begin
               state_in = (flush_start || flush_more) ? ST_RAW_READ : ST_IDLE;
            end
         end
         ST_MAC: begin
            if (mac_last) begin
               state_in = ST_MAC_DRAIN;
            end
         end
         ST_MAC_DRAIN: begin
            if (!sts.mac_busy) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_SMOOTH_OUT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // tap age, central-result flag and end flag
   always_comb begin
      age_in  = age_ff;
      main_in = main_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_is_last;
               priority if (!sts.cfg_valid) begin
                  main_in = 1'b0;
                  age_in  = '0;
               end else if (seen_ge_2m) begin
                  main_in = 1'b1;
                  age_in  = '0;
               end else if (seen_ge_m) begin
                  main_in = 1'b1;
                  age_in  = m_ext;
               end else begin
                  main_in = 1'b0;
                  age_in  = sts.seen[AGE_W-1:0];
               end
            end
         end
         ST_MAC: begin
            age_in = age_ff + 1'b1;
         end
         ST_RAW_OUT, ST_SMOOTH_OUT: begin
            if (sts.out_free) begin
               priority if (flush_start) begin
                  main_in = 1'b0;
                  age_in  = m_ext - 1'b1;
               end else if (flush_more) begin
                  age_in  = age_ff - 1'b1;
               end
            end
         end
         default: begin
            age_in = age_ff;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.rd_age      = age_ff;
      cmd.eor         = !main_ff && (age_ff == '0) && last_ff;
      unique case (state_ff)
         ST_RAW_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_RAW_OUT: begin
            cmd.load_raw = sts.out_free;
         end
         ST_MAC: begin
            cmd.rd_en     = 1'b1;
            cmd.mac       = 1'b1;
            cmd.acc_clear = age_ff == '0;
         end
         ST_MAC_DRAIN: begin
            cmd.div_start = !sts.mac_busy;
         end
         ST_SMOOTH_OUT: begin
            cmd.load_smooth = sts.out_free;
         end
         default: begin
            cmd.rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         age_ff   <= '0;
         main_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         age_ff   <= age_in;
         main_ff  <= main_in;
         last_ff  <= last_in;
      end
   end

   // checks
   `SGS_ASSERT_IMPLY(a_load_into_free_slot, clock, reset, cmd.load_raw || cmd.load_smooth, sts.out_free)
   `SGS_ASSERT_NEXT(a_div_starts_running, clock, reset, cmd.div_start, sts.div_busy)
   `SGS_ASSERT_IMPLY(a_no_accept_while_working, clock, reset, sts.mac_busy || sts.div_busy, !req_ready)

endmodule

`default_nettype wire

### hdl/savitzky_golay_smoother.sv
// raw results (edge samples, short runs, invalid settings): ring read, then output register load once it is free
// smoothed result: 2m+1 taps in ST_MAC, a drain of the multiply pipeline, then a radix-2 serial divide of the
//   SAMPLE_BITS+25-bit numerator
// one item at a time; the multiply-accumulate loop, the serial divider and output back-pressure set the rate
// reset is synchronous: window 5, order 2, sample count and ring pointer cleared
// ring contents are not cleared; only samples of the current run are read
`default_nettype none

module savitzky_golay_smoother
   import sgs_pkg::*;
#(
   parameter int MAX_WINDOW  = 25,
   parameter int RING_DEPTH  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_IN_W-1:0] req_sample,
   input  wire logic                   req_is_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [OUT_W-1:0]     rsp_smoothed,
   output logic                        rsp_end_of_run,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   sgs_cmd_type cmd;
   sgs_sts_type sts;

   // sequencing
   sgs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_is_last (req_is_last),
      .sts         (sts),
      .cmd         (cmd)
   );

   // storage, arithmetic and output register
   sgs_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req_sample),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_smoothed   (rsp_smoothed),
      .rsp_end_of_run (rsp_end_of_run),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

`default_nettype wire
